// ===== src/apf_pkg.sv =====
// package for the autocorrelation peak finder
// shared widths, constants and the queue entry type; no dependencies
package apf_pkg;

  localparam int SampleW   = 16;
  localparam int LagW      = 9;
  localparam int CountW    = 9;
  localparam int MaxLagsDefault = 512;
  localparam int QueueDepth     = 4;

  localparam logic KindPeak    = 1'b0;
  localparam logic KindSummary = 1'b1;

  localparam logic [CountW-1:0] CountCap = {CountW{1'b1}};

  // results caused by one item: an optional peak record, an optional summary
  typedef struct packed {
    logic                      has_peak;
    logic signed [SampleW-1:0] peak_value;
    logic [LagW-1:0]           peak_lag;
    logic                      has_sum;
    logic signed [SampleW-1:0] sum_value;
    logic [LagW-1:0]           sum_lag;
    logic [CountW-1:0]         sum_count;
  } apf_entry_t;

  // queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } apf_qstat_t;

endpackage

// ===== src/apf_if.sv =====
// stream interfaces for the peak finder: input items and result items
// depends on apf_pkg for field widths
interface apf_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [apf_pkg::SampleW-1:0] sample;
  logic                               frame_end;

  modport source (output valid, output sample, output frame_end, input ready);
  modport sink   (input valid, input sample, input frame_end, output ready);
endinterface

interface apf_out_if;
  logic                               valid;
  logic                               ready;
  logic                               kind;
  logic signed [apf_pkg::SampleW-1:0] peak_value;
  logic [apf_pkg::LagW-1:0]           peak_lag;
  logic [apf_pkg::CountW-1:0]         peak_count;
  logic                               last;

  modport source (output valid, output kind, output peak_value, output peak_lag,
                  output peak_count, output last, input ready);
  modport sink   (input valid, input kind, input peak_value, input peak_lag,
                  input peak_count, input last, output ready);
endinterface

// ===== src/apf_front.sv =====
// front part: accepts items, tracks lobes and maxima, builds queue entries
// depends on apf_pkg and apf_in_if
module apf_front #(
  parameter int MaxLags = apf_pkg::MaxLagsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  apf_in_if.sink              in_i,
  input  apf_pkg::apf_qstat_t qstat_i,
  output logic                push_o,
  output apf_pkg::apf_entry_t entry_o
);
  import apf_pkg::*;

  localparam int LagCap = ((MaxLags - 1) < 511) ? (MaxLags - 1) : 511;

  logic [LagW-1:0]           lag_q, lag_d;
  logic                      past_q, past_d;
  logic signed [SampleW-1:0] prev_q, prev_d;
  logic signed [SampleW-1:0] lmax_q, lmax_d;
  logic [LagW-1:0]           llag_q, llag_d;
  logic signed [SampleW-1:0] gmax_q, gmax_d;
  logic [LagW-1:0]           glag_q, glag_d;
  logic [CountW-1:0]         cnt_q, cnt_d;

  logic accept;
  logic peak_fire;
  logic signed [SampleW-1:0] cur;
  logic prev_pos, cur_pos;

  assign in_i.ready = !qstat_i.full;
  assign accept     = in_i.valid && in_i.ready;
  assign cur        = in_i.sample;
  assign prev_pos   = !prev_q[SampleW-1];
  assign cur_pos    = !cur[SampleW-1];

  // lobe tracking and next frame state
  always_comb begin
    lag_d     = lag_q;
    past_d    = past_q;
    prev_d    = prev_q;
    lmax_d    = lmax_q;
    llag_d    = llag_q;
    gmax_d    = gmax_q;
    glag_d    = glag_q;
    cnt_d     = cnt_q;
    peak_fire = 1'b0;
    if (lag_q != '0) begin
      if (past_q) begin
        if (prev_pos && cur_pos) begin
          if (cur > lmax_q) begin
            lmax_d = cur;
            llag_d = lag_q;
            if (cur > gmax_q) begin
              gmax_d = cur;
              glag_d = lag_q;
            end
          end
        end else if (prev_pos && !cur_pos) begin
          if (gmax_q > 0) begin
            peak_fire = 1'b1;
            if (cnt_q < CountCap) cnt_d = cnt_q + 1'b1;
          end
        end else if (!prev_pos && cur_pos) begin
          lmax_d = cur;
          llag_d = lag_q;
          if (cur > gmax_q) begin
            gmax_d = cur;
            glag_d = lag_q;
          end
        end
      end else if (cur <= 0) begin
        past_d = 1'b1;
      end
    end
    prev_d = cur;
    if (lag_q < LagW'(LagCap)) lag_d = lag_q + 1'b1;

    // entry: peak from the current lobe state, summary from the updated state
    entry_o.has_peak   = peak_fire;
    entry_o.peak_value = lmax_q;
    entry_o.peak_lag   = llag_q;
    entry_o.has_sum    = in_i.frame_end;
    entry_o.sum_value  = gmax_d;
    entry_o.sum_lag    = glag_d;
    entry_o.sum_count  = cnt_d;

    // frame end returns to the reset state
    if (in_i.frame_end) begin
      lag_d  = '0;
      past_d = 1'b0;
      prev_d = '0;
      lmax_d = '0;
      llag_d = '0;
      gmax_d = '0;
      glag_d = '0;
      cnt_d  = '0;
    end
  end

  assign push_o = accept && (peak_fire || in_i.frame_end);

  // frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lag_q  <= '0;
      past_q <= 1'b0;
      prev_q <= '0;
      lmax_q <= '0;
      llag_q <= '0;
      gmax_q <= '0;
      glag_q <= '0;
      cnt_q  <= '0;
    end else if (accept) begin
      lag_q  <= lag_d;
      past_q <= past_d;
      prev_q <= prev_d;
      lmax_q <= lmax_d;
      llag_q <= llag_d;
      gmax_q <= gmax_d;
      glag_q <= glag_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ===== src/apf_queue.sv =====
// small register queue of result entries between front and back
// depends on apf_pkg
module apf_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  apf_pkg::apf_entry_t entry_i,
  input  logic                pop_i,
  output apf_pkg::apf_entry_t head_o,
  output apf_pkg::apf_qstat_t qstat_o
);
  import apf_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  apf_entry_t        mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;

  assign head_o        = mem_q[rd_q];
  assign qstat_o.full  = (cnt_q == CntW'(QueueDepth));
  assign qstat_o.empty = (cnt_q == '0);

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= entry_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== src/apf_back.sv =====
// back part: splits queue entries into result items, output register
// depends on apf_pkg and apf_out_if
module apf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  apf_pkg::apf_entry_t head_i,
  input  apf_pkg::apf_qstat_t qstat_i,
  output logic                pop_o,
  apf_out_if.source           out_o
);
  import apf_pkg::*;

  logic                      valid_q;
  logic                      phase_q, phase_d;
  logic                      kind_q, kind_d;
  logic signed [SampleW-1:0] value_q, value_d;
  logic [LagW-1:0]           lag_q, lag_d;
  logic [CountW-1:0]         count_q, count_d;
  logic                      last_q, last_d;
  logic                      load;

  assign load = !qstat_i.empty && (!valid_q || out_o.ready);

  // pick the next record of the head entry
  always_comb begin
    phase_d = phase_q;
    pop_o   = 1'b0;
    if (head_i.has_peak && !phase_q) begin
      kind_d  = KindPeak;
      value_d = head_i.peak_value;
      lag_d   = head_i.peak_lag;
      count_d = '0;
      last_d  = 1'b0;
      if (load) begin
        if (head_i.has_sum) phase_d = 1'b1;
        else pop_o = 1'b1;
      end
    end else begin
      kind_d  = KindSummary;
      value_d = head_i.sum_value;
      lag_d   = head_i.sum_lag;
      count_d = head_i.sum_count;
      last_d  = 1'b1;
      if (load) begin
        pop_o   = 1'b1;
        phase_d = 1'b0;
      end
    end
  end

  // output control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (load) valid_q <= 1'b1;
      else if (out_o.ready) valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q  <= kind_d;
      value_q <= value_d;
      lag_q   <= lag_d;
      count_q <= count_d;
      last_q  <= last_d;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.kind       = kind_q;
  assign out_o.peak_value = value_q;
  assign out_o.peak_lag   = lag_q;
  assign out_o.peak_count = count_q;
  assign out_o.last       = last_q;

endmodule

// ===== src/autocorr_peak_finder.sv =====
// autocorrelation peak finder: one item accepted per cycle while the queue has room
// an accepted item's results enter the queue, then the output register once it is free
// throughput: one item per cycle while the queue has room; an item ending a lobe
// on the last lag gives two results, held in the queue and delivered in turn
// reset: asynchronous, active low; clears the frame state, queue pointers and output valid
// depends on apf_pkg, apf_if, apf_front, apf_queue, apf_back
module autocorr_peak_finder #(
  parameter int MaxLags = apf_pkg::MaxLagsDefault
) (
  input logic       clk_i,
  input logic       rst_ni,
  apf_in_if.sink    in_i,
  apf_out_if.source out_o
);
  import apf_pkg::*;

  apf_entry_t push_entry, head;
  apf_qstat_t qstat;
  logic       push, pop;

  // front: lobe tracking
  apf_front #(.MaxLags(MaxLags)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .qstat_i (qstat),
    .push_o  (push),
    .entry_o (push_entry)
  );

  // queue between front and back
  apf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head),
    .qstat_o (qstat)
  );

  // back: result delivery
  apf_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .qstat_i (qstat),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// ===== src/apf_checker.sv =====
// port-level checks for the autocorrelation peak finder, bound to the top level
// depends on apf_pkg and autocorr_peak_finder
module apf_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic                               out_kind_i,
  input logic signed [apf_pkg::SampleW-1:0] out_value_i,
  input logic [apf_pkg::LagW-1:0]           out_lag_i,
  input logic [apf_pkg::CountW-1:0]         out_count_i,
  input logic                               out_last_i
);
  import apf_pkg::*;

  // a stalled result request stays offered
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped while stalled");

  // a stalled result request holds its payload
  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_kind_i) && $stable(out_value_i)
      && $stable(out_lag_i) && $stable(out_count_i) && $stable(out_last_i))
    else $error("result payload changed while stalled");

  // only the summary closes a frame
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_last_i == (out_kind_i == KindSummary)))
    else $error("last flag does not match result kind");

  // peak records carry no count
  a_peak_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i == KindPeak) |-> (out_count_i == '0))
    else $error("peak record with nonzero count");

endmodule

bind autocorr_peak_finder apf_checker u_apf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_kind_i  (out_o.kind),
  .out_value_i (out_o.peak_value),
  .out_lag_i   (out_o.peak_lag),
  .out_count_i (out_o.peak_count),
  .out_last_i  (out_o.last)
);
